@@ src/grh_pkg.sv @@
// Grouped repeat histogram: shared types, constants and helpers.
// Depends on nothing; grh_csr, grh_group_table and the top level import it.
`timescale 1ns / 1ps

package grh_pkg;

   localparam int MAX_GROUPS  = 16;
   localparam int MAX_LOCI    = 32;
   localparam int MAX_REPEAT  = 63;
   localparam int COUNT_WIDTH = 16;

   localparam int VALUE_W    = 16;
   localparam int SLOT_W     = 4;
   localparam int LOCUS_W    = 5;
   localparam int BIN_W      = 6;
   localparam int GCOUNT_W   = 5;
   localparam int POS_W      = 6;
   localparam int NUM_LOCI_W = 6;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;

   localparam int HIST_DEPTH  = MAX_GROUPS * MAX_LOCI * (MAX_REPEAT + 1);
   localparam int HIST_ADDR_W = SLOT_W + LOCUS_W + BIN_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_NUM_LOCI = '0;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef enum logic [CMD_W-1:0] {
      CMD_DATA       = 2'd0,
      CMD_READ_BIN   = 2'd1,
      CMD_READ_GROUP = 2'd2,
      CMD_NOP        = 2'd3
   } grh_cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_TOO_LARGE = 2'd2,
      STATUS_MISSING   = 2'd3
   } grh_status_type;

   typedef enum logic [1:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_EXEC
   } grh_fsm_type;

   typedef struct packed {
      logic [NUM_LOCI_W-1:0] num_loci;
      logic                  restart;
   } grh_cfg_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } grh_lookup_type;

   typedef struct packed {
      grh_cmd_type              cmd;
      logic                     is_id;
      logic [VALUE_W-1:0]       value;
      logic [SLOT_W-1:0]        slot;
      logic                     hit;
      logic [SLOT_W-1:0]        hit_slot;
      logic [HIST_ADDR_W-1:0]   hist_addr;
   } grh_item_type;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] count);
      return (count == COUNT_MAX) ? count : count + 1'b1;
   endfunction

endpackage

@@ src/grh_ram.sv @@
// Generic single-clock RAM: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module grh_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/grh_csr.sv @@
// Configuration register file of the grouped repeat histogram (num_loci).
// Depends on grh_pkg.
`timescale 1ns / 1ps

module grh_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [grh_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [grh_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [grh_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output grh_pkg::grh_cfg_type             cfg
);
   import grh_pkg::*;

   logic [NUM_LOCI_W-1:0] num_loci_ff;
   logic [NUM_LOCI_W-1:0] num_loci_in;
   logic                  wr_hit;

   assign wr_hit = csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[CSR_ADDR_W-1:2] == REG_NUM_LOCI);

   assign num_loci_in = wr_hit ? csr_pwdata[NUM_LOCI_W-1:0] : num_loci_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_loci_ff <= NUM_LOCI_W'(1);
      end else begin
         num_loci_ff <= num_loci_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == REG_NUM_LOCI)
                       ? CSR_DATA_W'(num_loci_ff) : '0;

   // restart framing on every write of num_loci
   assign cfg.num_loci = num_loci_ff;
   assign cfg.restart  = wr_hit;

endmodule

@@ src/grh_group_table.sv @@
// Group id table: stored ids, fill count and a parallel id lookup.
// Depends on grh_pkg.
`timescale 1ns / 1ps

module grh_group_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [grh_pkg::VALUE_W-1:0]     lookup_id,
   output grh_pkg::grh_lookup_type         lookup,
   input  logic                            add_en,
   input  logic [grh_pkg::VALUE_W-1:0]     add_id,
   input  logic [grh_pkg::SLOT_W-1:0]      rd_slot,
   output logic [grh_pkg::VALUE_W-1:0]     rd_id,
   output logic [grh_pkg::GCOUNT_W-1:0]    used_count,
   output logic                            full
);
   import grh_pkg::*;

   logic [VALUE_W-1:0]  ids_ff [MAX_GROUPS];
   logic [GCOUNT_W-1:0] used_ff;
   logic [GCOUNT_W-1:0] used_in;

   // ids in use are unique, so any matching slot is the one
   always_comb begin
      lookup.hit  = 1'b0;
      lookup.slot = '0;
      for (int i = MAX_GROUPS - 1; i >= 0; i--) begin
         if ((GCOUNT_W'(i) < used_ff) && (ids_ff[i] == lookup_id)) begin
            lookup.hit  = 1'b1;
            lookup.slot = SLOT_W'(i);
         end
      end
   end

   assign full    = (used_ff == GCOUNT_W'(MAX_GROUPS));
   assign used_in = add_en ? used_ff + 1'b1 : used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (add_en) begin
         ids_ff[used_ff[SLOT_W-1:0]] <= add_id;
      end
   end

   assign rd_id      = ids_ff[rd_slot];
   assign used_count = used_ff;

endmodule

@@ src/grouped_repeat_histogram_top.sv @@
// Grouped repeat histogram, top level: framing control, histogram and
// sample-size memories, result register. Depends on grh_pkg, grh_ram,
// grh_csr and grh_group_table.
//
//   channel | direction | handshake              | contents
//   req     | in        | req_tvalid/req_tready  | tuser command, tdata token and read address
//   rsp     | out       | rsp_tvalid/rsp_tready  | tuser status, tlast record end, tdata read data
//   csr     | in        | psel/penable, pready=1 | num_loci at byte address 0
//
// Each word is handled in steps: the accept cycle issues the memory reads and
// the group lookup; the EXEC state then modifies and writes back once the
// result register is free. The histogram read-modify-write sets this split.
// After reset a clearing pass zeroes all 32768 histogram entries, one entry a
// cycle, with req_tready low.
// The result register holds while rsp stalls; a new word is still accepted,
// and its update waits until the result register is free.
`timescale 1ns / 1ps

module grouped_repeat_histogram_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [15:0] value, [19:16] group_slot, [24:20] locus, [30:25] repeat_bin
   input  logic [31:0]                          req_tdata,
   // [1:0] command
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] bin_count, [31:16] group_id, [47:32] sample_size,
   // [52:48] group_count, [58:53] max_repeat
   output logic [63:0]                          rsp_tdata,
   // [1:0] status
   output logic [1:0]                           rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [grh_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [grh_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [grh_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);
   import grh_pkg::*;

   grh_cfg_type    cfg;
   grh_lookup_type lookup;

   grh_fsm_type state_ff, state_in;
   logic        clearing, in_exec, accept, exec_go;

   logic [HIST_ADDR_W-1:0] clear_addr_ff, clear_addr_in;
   logic                   clear_last;

   grh_item_type item_ff, item_in;

   logic [POS_W-1:0]   locus_pos_ff, locus_pos_in, pos_next, loci_eff;
   logic [SLOT_W-1:0]  cur_slot_ff, cur_slot_in;
   logic               dropped_ff, dropped_in;
   logic [BIN_W-1:0]   largest_ff, largest_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic               rsp_done_ff;
   logic [63:0]        rsp_data_ff;

   grh_cmd_type        req_cmd;
   logic [VALUE_W-1:0] req_value;
   logic [SLOT_W-1:0]  req_slot;
   logic [LOCUS_W-1:0] req_locus;
   logic [BIN_W-1:0]   req_bin;

   logic [COUNT_WIDTH-1:0] hist_rd, sample_rd;
   logic                   hist_wr_en;
   logic [HIST_ADDR_W-1:0] hist_wr_addr;
   logic [COUNT_WIDTH-1:0] hist_wr_data;
   logic [SLOT_W-1:0]      sample_rd_addr;

   logic [VALUE_W-1:0]  table_rd_id;
   logic [GCOUNT_W-1:0] used_count;
   logic                table_full;

   grh_status_type         st;
   logic                   done;
   logic [COUNT_WIDTH-1:0] bc, ss;
   logic [VALUE_W-1:0]     gid;
   logic [GCOUNT_W-1:0]    gc_out;
   logic                   group_add, sample_wr, hist_upd;
   logic [SLOT_W-1:0]      sample_wr_addr;
   logic [COUNT_WIDTH-1:0] sample_wr_data;

   grh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // unpack the input word
   assign req_cmd   = grh_cmd_type'(req_tuser[CMD_W-1:0]);
   assign req_value = req_tdata[15:0];
   assign req_slot  = req_tdata[19:16];
   assign req_locus = req_tdata[24:20];
   assign req_bin   = req_tdata[30:25];

   // ---------------- state machine ----------------
   assign clear_last = (clear_addr_ff == {HIST_ADDR_W{1'b1}});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_CLEAR: begin
            if (clear_last) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (req_tvalid) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_CLEAR;
         end
      endcase
   end

   always_comb begin
      clearing   = 1'b0;
      req_tready = 1'b0;
      in_exec    = 1'b0;
      unique case (state_ff)
         FSM_CLEAR: clearing   = 1'b1;
         FSM_IDLE:  req_tready = 1'b1;
         FSM_EXEC:  in_exec    = 1'b1;
         default:   clearing   = 1'b0;
      endcase
   end

   assign accept        = req_tvalid && req_tready;
   assign exec_go       = in_exec && (!rsp_valid_ff || rsp_tready);
   assign clear_addr_in = clearing ? clear_addr_ff + 1'b1 : clear_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_CLEAR;
         clear_addr_ff <= '0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   // ---------------- accept: decode, lookup, issue reads ----------------
   grh_group_table u_table (
      .clock      (clock),
      .reset      (reset),
      .lookup_id  (req_value),
      .lookup     (lookup),
      .add_en     (group_add && exec_go),
      .add_id     (item_ff.value),
      .rd_slot    (item_ff.slot),
      .rd_id      (table_rd_id),
      .used_count (used_count),
      .full       (table_full)
   );

   always_comb begin
      item_in.cmd      = req_cmd;
      item_in.is_id    = (req_cmd == CMD_DATA) && (locus_pos_ff == '0);
      item_in.value    = req_value;
      item_in.slot     = req_slot;
      item_in.hit      = lookup.hit;
      item_in.hit_slot = lookup.slot;
      if (req_cmd == CMD_READ_BIN) begin
         item_in.hist_addr = {req_slot, req_locus, req_bin};
      end else begin
         item_in.hist_addr = {cur_slot_ff, LOCUS_W'(locus_pos_ff - 1'b1),
                              req_value[BIN_W-1:0]};
      end
   end

   assign sample_rd_addr = (req_cmd == CMD_READ_GROUP) ? req_slot : lookup.slot;

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   // ---------------- memories ----------------
   assign hist_wr_en   = clearing || (hist_upd && exec_go);
   assign hist_wr_addr = clearing ? clear_addr_ff : item_ff.hist_addr;
   assign hist_wr_data = clearing ? '0 : sat_inc(hist_rd);

   grh_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (HIST_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_en   (accept),
      .rd_addr (item_in.hist_addr),
      .rd_data (hist_rd)
   );

   // entries at or above the fill count read as zero, so no clearing is needed
   grh_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (MAX_GROUPS)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (sample_wr && exec_go),
      .wr_addr (sample_wr_addr),
      .wr_data (sample_wr_data),
      .rd_en   (accept),
      .rd_addr (sample_rd_addr),
      .rd_data (sample_rd)
   );

   // ---------------- update ----------------
   always_comb begin
      if (cfg.num_loci == '0) begin
         loci_eff = POS_W'(1);
      end else if (cfg.num_loci > NUM_LOCI_W'(MAX_LOCI)) begin
         loci_eff = POS_W'(MAX_LOCI);
      end else begin
         loci_eff = cfg.num_loci;
      end
   end

   assign pos_next = locus_pos_ff + 1'b1;

   always_comb begin
      st             = STATUS_OK;
      done           = 1'b0;
      bc             = '0;
      gid            = '0;
      ss             = '0;
      locus_pos_in   = locus_pos_ff;
      dropped_in     = dropped_ff;
      cur_slot_in    = cur_slot_ff;
      largest_in     = largest_ff;
      group_add      = 1'b0;
      sample_wr      = 1'b0;
      hist_upd       = 1'b0;
      sample_wr_addr = item_ff.hit_slot;
      sample_wr_data = sat_inc(sample_rd);
      unique case (item_ff.cmd)
         CMD_DATA: begin
            if (item_ff.is_id) begin
               locus_pos_in = POS_W'(1);
               dropped_in   = 1'b0;
               priority if (item_ff.hit) begin
                  sample_wr   = 1'b1;
                  cur_slot_in = item_ff.hit_slot;
               end else if (!table_full) begin
                  group_add      = 1'b1;
                  sample_wr      = 1'b1;
                  sample_wr_addr = used_count[SLOT_W-1:0];
                  sample_wr_data = COUNT_WIDTH'(1);
                  cur_slot_in    = used_count[SLOT_W-1:0];
               end else begin
                  dropped_in = 1'b1;
                  st         = STATUS_FULL;
               end
            end else begin
               priority if (dropped_ff) begin
                  st = STATUS_FULL;
               end else if (item_ff.value[VALUE_W-1]) begin
                  st = STATUS_MISSING;
               end else if (item_ff.value > VALUE_W'(MAX_REPEAT)) begin
                  st = STATUS_TOO_LARGE;
               end else begin
                  hist_upd = 1'b1;
                  if (item_ff.value[BIN_W-1:0] > largest_ff) begin
                     largest_in = item_ff.value[BIN_W-1:0];
                  end
               end
               // close the record after its last count
               if (pos_next > loci_eff) begin
                  locus_pos_in = '0;
                  dropped_in   = 1'b0;
                  done         = 1'b1;
               end else begin
                  locus_pos_in = pos_next;
               end
            end
         end
         CMD_READ_BIN: begin
            bc = hist_rd;
         end
         CMD_READ_GROUP: begin
            if (GCOUNT_W'(item_ff.slot) < used_count) begin
               gid = table_rd_id;
               ss  = sample_rd;
            end
         end
         CMD_NOP: begin
            st = STATUS_OK;
         end
         default: begin
            st = STATUS_OK;
         end
      endcase
      gc_out = used_count + GCOUNT_W'(group_add);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         locus_pos_ff <= '0;
         dropped_ff   <= 1'b0;
         cur_slot_ff  <= '0;
         largest_ff   <= '0;
      end else if (cfg.restart) begin
         locus_pos_ff <= '0;
         dropped_ff   <= 1'b0;
      end else if (exec_go) begin
         locus_pos_ff <= locus_pos_in;
         dropped_ff   <= dropped_in;
         cur_slot_ff  <= cur_slot_in;
         largest_ff   <= largest_in;
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_status_ff <= st;
         rsp_done_ff   <= done;
         rsp_data_ff   <= {5'b0, largest_in, gc_out, ss, gid, bc};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_done_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
